// ----- sv/spr_pkg.sv -----
// shared types and constants for the stepper phase and ramp sequencer
package spr_pkg;

   localparam int COUNT_BITS = 24;
   localparam int REM_BITS   = COUNT_BITS - 1;
   localparam int SPEED_BITS = 32;
   localparam int CSR_BITS   = 3;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_STEP = 1'b1;

   localparam logic [CSR_BITS-1:0] CSR_START_SPEED = 3'd0;
   localparam logic [CSR_BITS-1:0] CSR_MAX_SPEED   = 3'd1;
   localparam logic [CSR_BITS-1:0] CSR_ACCEL_STEP  = 3'd2;
   localparam logic [CSR_BITS-1:0] CSR_PHASE_ROW_0 = 3'd3;
   localparam logic [CSR_BITS-1:0] CSR_PHASE_ROW_1 = 3'd4;
   localparam logic [CSR_BITS-1:0] CSR_PHASE_ROW_2 = 3'd5;
   localparam logic [CSR_BITS-1:0] CSR_PHASE_ROW_3 = 3'd6;

   localparam logic [SPEED_BITS-1:0] START_SPEED_RESET = 32'h0001_0000;
   localparam logic [SPEED_BITS-1:0] MAX_SPEED_RESET   = 32'h0001_0000;
   localparam logic [3:0] PHASE_ROW_0_RESET = 4'd12;
   localparam logic [3:0] PHASE_ROW_1_RESET = 4'd6;
   localparam logic [3:0] PHASE_ROW_2_RESET = 4'd3;
   localparam logic [3:0] PHASE_ROW_3_RESET = 4'd9;

   typedef enum logic [1:0] {
      MODE_CRUISE = 2'd0,
      MODE_ACCEL  = 2'd1,
      MODE_DECEL  = 2'd2
   } mode_type;

   typedef struct packed {
      logic                         op;
      logic signed [COUNT_BITS-1:0] move_count;
   } req_type;

   typedef struct packed {
      logic                  stepped;
      logic                  load_taken;
      logic [3:0]            coil_pattern;
      logic [REM_BITS-1:0]   steps_left;
      logic [SPEED_BITS-1:0] speed_now;
      logic                  dir_cw;
   } rsp_type;

   typedef struct packed {
      logic [SPEED_BITS-1:0] start_speed;
      logic [SPEED_BITS-1:0] max_speed;
      logic [SPEED_BITS-1:0] accel_step;
      logic [3:0][3:0]       phase_rows;
   } cfg_type;

   typedef struct packed {
      logic [1:0]            phase_index;
      logic [REM_BITS-1:0]   remaining_steps;
      logic [COUNT_BITS-1:0] decel_point;
      mode_type              ramp_mode;
      logic [SPEED_BITS-1:0] current_speed;
      logic                  direction;
   } state_type;

endpackage

// ----- sv/spr_step_logic.sv -----
// next-state and result logic for one load or step word
module spr_step_logic (
   input  spr_pkg::state_type cur,
   input  spr_pkg::cfg_type   cfg,
   input  spr_pkg::req_type   req,
   output spr_pkg::state_type nxt,
   output spr_pkg::rsp_type   rsp
);

   logic                            neg;
   logic [spr_pkg::COUNT_BITS-1:0]  raw;
   logic [spr_pkg::COUNT_BITS-1:0]  mag;
   logic [spr_pkg::REM_BITS-1:0]    rem_new;
   logic [1:0]                      row;
   logic [spr_pkg::SPEED_BITS:0]    sum;
   logic [spr_pkg::SPEED_BITS-1:0]  spd;
   logic [spr_pkg::COUNT_BITS-1:0]  dp;
   spr_pkg::mode_type               mode_v;

   assign raw = req.move_count;
   assign neg = raw[spr_pkg::COUNT_BITS-1];
   assign mag = (~raw) + {{(spr_pkg::COUNT_BITS-1){1'b0}}, 1'b1};
   assign rem_new = cur.remaining_steps - {{(spr_pkg::REM_BITS-1){1'b0}}, 1'b1};
   // clockwise walks the table backward
   assign row = cur.direction ? ~cur.phase_index : cur.phase_index;
   assign sum = {1'b0, cur.current_speed} + {1'b0, cfg.accel_step};

   always_comb begin
      nxt = cur;
      rsp = '0;
      spd = cur.current_speed;
      dp = cur.decel_point;
      mode_v = cur.ramp_mode;
      if (req.op == spr_pkg::OP_LOAD) begin
         if (cur.remaining_steps == '0) begin
            if (neg) begin
               // most negative count saturates to the largest magnitude
               nxt.remaining_steps = mag[spr_pkg::COUNT_BITS-1] ? '1
                                     : mag[spr_pkg::REM_BITS-1:0];
            end else begin
               nxt.remaining_steps = raw[spr_pkg::REM_BITS-1:0];
            end
            nxt.direction = !neg && (raw != '0);
            nxt.decel_point = {2'b00, nxt.remaining_steps[spr_pkg::REM_BITS-1:1]};
            nxt.ramp_mode = spr_pkg::MODE_ACCEL;
            nxt.current_speed = cfg.start_speed;
            rsp.load_taken = 1'b1;
         end
      end else if (cur.remaining_steps != '0) begin
         rsp.stepped = 1'b1;
         rsp.coil_pattern = cfg.phase_rows[row];
         nxt.phase_index = cur.phase_index + 2'd1;
         nxt.remaining_steps = rem_new;
         if (cfg.accel_step != '0) begin
            unique case (cur.ramp_mode)
               spr_pkg::MODE_ACCEL: begin
                  spd = (sum >= {1'b0, cfg.max_speed}) ? cfg.max_speed
                        : sum[spr_pkg::SPEED_BITS-1:0];
               end
               spr_pkg::MODE_DECEL: begin
                  spd = (cur.current_speed > cfg.accel_step)
                        ? cur.current_speed - cfg.accel_step : '0;
               end
               default: begin
                  spd = cur.current_speed;
               end
            endcase
            // reaching the limit moves the ramp-down point by what acceleration used
            if (cur.ramp_mode != spr_pkg::MODE_CRUISE && spd >= cfg.max_speed) begin
               mode_v = spr_pkg::MODE_CRUISE;
               dp = (cur.decel_point << 1) - {1'b0, rem_new}
                    + spr_pkg::COUNT_BITS'(2);
            end
            if ({1'b0, rem_new} == dp) begin
               mode_v = spr_pkg::MODE_DECEL;
            end
            nxt.current_speed = spd;
            nxt.decel_point = dp;
            nxt.ramp_mode = mode_v;
         end
      end
      rsp.steps_left = nxt.remaining_steps;
      rsp.speed_now = nxt.current_speed;
      rsp.dir_cw = nxt.direction;
   end

endmodule

// ----- sv/stepper_phase_and_ramp_sequencer.sv -----
// top level of the four-phase stepper sequencer with trapezoidal ramp
//
// req channel: one word per load (op 0, signed move_count) or step (op 1).
// a load is taken only while no steps remain; otherwise it is dropped and
// its result shows load_taken 0. every step word gives one coil pattern,
// or zero coils with stepped 0 when the move has finished.
// rsp channel: exactly one result word per request word, in order.
// latency: the result is valid in the cycle after the request is accepted.
// throughput: one word per cycle while req_stall is low; the whole
// update (phase, count, ramp add and compare) is combinational logic
// from the state registers into the result register.
// when the receiver stalls, the result register holds and req_stall rises
// only while that held word is not taken, so the input sees the stall in
// the same cycle it is released.
// csr port: write-only, taken in any cycle with csr_we high; write only
// while no word is in flight.
// reset (synchronous): empties the result register, sets the registers to
// their documented defaults and the sequencer to an idle clockwise state.
module stepper_phase_and_ramp_sequencer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  spr_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output spr_pkg::rsp_type                rsp_data,
   input  logic                            csr_we,
   input  logic [spr_pkg::CSR_BITS-1:0]    csr_index,
   input  logic [spr_pkg::SPEED_BITS-1:0]  csr_wdata
);

   spr_pkg::state_type state_ff, state_in;
   spr_pkg::cfg_type   cfg_ff, cfg_in;
   spr_pkg::rsp_type   rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               accept;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   spr_step_logic u_step (
      .cur (state_ff),
      .cfg (cfg_ff),
      .req (req_data),
      .nxt (state_in),
      .rsp (rsp_in)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            spr_pkg::CSR_START_SPEED: cfg_in.start_speed = csr_wdata;
            spr_pkg::CSR_MAX_SPEED:   cfg_in.max_speed = csr_wdata;
            spr_pkg::CSR_ACCEL_STEP:  cfg_in.accel_step = csr_wdata;
            spr_pkg::CSR_PHASE_ROW_0: cfg_in.phase_rows[0] = csr_wdata[3:0];
            spr_pkg::CSR_PHASE_ROW_1: cfg_in.phase_rows[1] = csr_wdata[3:0];
            spr_pkg::CSR_PHASE_ROW_2: cfg_in.phase_rows[2] = csr_wdata[3:0];
            spr_pkg::CSR_PHASE_ROW_3: cfg_in.phase_rows[3] = csr_wdata[3:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         state_ff <= '{phase_index: '0, remaining_steps: '0, decel_point: '0,
                       ramp_mode: spr_pkg::MODE_CRUISE, current_speed: '0,
                       direction: 1'b1};
         cfg_ff.start_speed <= spr_pkg::START_SPEED_RESET;
         cfg_ff.max_speed <= spr_pkg::MAX_SPEED_RESET;
         cfg_ff.accel_step <= '0;
         cfg_ff.phase_rows[0] <= spr_pkg::PHASE_ROW_0_RESET;
         cfg_ff.phase_rows[1] <= spr_pkg::PHASE_ROW_1_RESET;
         cfg_ff.phase_rows[2] <= spr_pkg::PHASE_ROW_2_RESET;
         cfg_ff.phase_rows[3] <= spr_pkg::PHASE_ROW_3_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff <= cfg_in;
         if (accept) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ----- sv/spr_checker.sv -----
// port-level assertions for the sequencer, bound to the top level
module spr_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input spr_pkg::rsp_type rsp_data
);

   // a held result word does not move
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result word changed");

   // each accepted request word shows up as a result in the next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted word produced no result");

   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.stepped && rsp_data.load_taken))
      else $error("result both stepped and took a load");

   // no step means coils are off
   a_idle_coils: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.stepped |-> rsp_data.coil_pattern == 4'd0)
      else $error("coils driven without a step");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind stepper_phase_and_ramp_sequencer spr_checker u_spr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
